>>> hdl/cmtr_pkg.sv
// ----------------------------------------------------------------------------
// cmtr_pkg
// Types and widths shared by the triangle row generator, its channel
// interfaces and its root extraction stages.
// ----------------------------------------------------------------------------
package cmtr_pkg;

  localparam int VERT_W  = 20;
  localparam int COL_W   = 21;
  localparam int COORD_W = 32;
  localparam int COEF_W  = 48;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 66;
  localparam int SUM_W   = 68;
  localparam int MAG_W   = 67;
  localparam int LO_W    = 34;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 136;
  localparam int ROOT_W  = 34;
  localparam int RES_W   = 140;

  localparam int LANE_EDGE  = 0;
  localparam int LANE_DOT   = 1;
  localparam int LANE_CROSS = 2;

  typedef struct packed {
    logic        [VERT_W-1:0]  first_vertex;
    logic        [VERT_W-1:0]  second_vertex;
    logic        [VERT_W-1:0]  third_vertex;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_y;
    logic signed [COORD_W-1:0] third_z;
  } in_word_t;

  typedef struct packed {
    logic                     imag_last;
    logic                     degenerate;
    logic        [COL_W-1:0]  col_first_u;
    logic        [COL_W-1:0]  col_first_v;
    logic        [COL_W-1:0]  col_second_u;
    logic        [COL_W-1:0]  col_second_v;
    logic        [COL_W-1:0]  col_third;
    logic signed [COEF_W-1:0] coef_first_u;
    logic signed [COEF_W-1:0] coef_first_v;
    logic signed [COEF_W-1:0] coef_second_u;
    logic signed [COEF_W-1:0] coef_second_v;
    logic signed [COEF_W-1:0] coef_third;
  } out_word_t;

  typedef struct packed {
    logic [VERT_W-1:0] vert0;
    logic [VERT_W-1:0] vert1;
    logic [VERT_W-1:0] vert2;
    logic              degenerate;
    logic              dot_neg;
  } tri_tag_t;

  // remainder, running root times divisor, divisor, partial root
  typedef struct packed {
    logic [RES_W-1:0]  rem;
    logic [RES_W-1:0]  acc;
    logic [PROD_W-1:0] div;
    logic [ROOT_W-1:0] root;
  } root_lane_t;

  typedef struct packed {
    tri_tag_t            tag;
    root_lane_t [2:0]    lane;
  } root_word_t;

endpackage

>>> hdl/cmtr_in_if.sv
// ----------------------------------------------------------------------------
// cmtr_in_if
// Triangle channel: valid, ready and one triangle word.
// ----------------------------------------------------------------------------
interface cmtr_in_if;
  import cmtr_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cmtr_out_if.sv
// ----------------------------------------------------------------------------
// cmtr_out_if
// Row channel: valid, ready and one equation row word.
// ----------------------------------------------------------------------------
interface cmtr_out_if;
  import cmtr_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cmtr_root_stage.sv
// ----------------------------------------------------------------------------
// cmtr_root_stage
// One bit of the root of rem / div on three lanes, registered.
// ----------------------------------------------------------------------------
module cmtr_root_stage #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_in,
  input  cmtr_pkg::root_word_t word_in,
  output logic                valid_out,
  output cmtr_pkg::root_word_t word_out
);
  import cmtr_pkg::*;

  root_word_t       word_nxt;
  root_word_t       word_r;
  logic             valid_r;
  logic [RES_W-1:0] term [3];

  always_comb begin
    word_nxt = word_in;
    for (int k = 0; k < 3; k++) begin
      term[k] = (word_in.lane[k].acc << (BIT + 1))
              + (RES_W'(word_in.lane[k].div) << (2 * BIT));
      if (word_in.lane[k].rem >= term[k]) begin
        word_nxt.lane[k].rem  = word_in.lane[k].rem - term[k];
        word_nxt.lane[k].acc  = word_in.lane[k].acc + (RES_W'(word_in.lane[k].div) << BIT);
        word_nxt.lane[k].root = word_in.lane[k].root | (ROOT_W'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;
endmodule

>>> hdl/conformal_map_triangle_rows.sv
// ----------------------------------------------------------------------------
// conformal_map_triangle_rows
// Builds the two conformal map equation rows of one triangle.
// ----------------------------------------------------------------------------
// Usage: one triangle word (three vertex indices, three Q16.16 points) goes
// in on in_ch; two row words come out on out_ch, the real row first and the
// imaginary row, flagged by imag_last, second.
// The datapath is a pipeline of 43 register stages: edge differences,
// products, sums, magnitudes, square partial products, squares, sums of
// squares, 34 root stages (one root bit each, three lanes) and the
// coefficient stage, then the output register.
// A triangle may enter every cycle in which in_ch.ready is high; in_ch.ready
// is low while the output register holds a triangle whose imaginary row is
// not yet taken, since it sends two row words per triangle.
// When out_ch stalls the whole pipeline holds and in_ch.ready drops; nothing
// is lost or sent twice.
// Reset (rst_n low at a clock edge) empties every stage.
// ----------------------------------------------------------------------------
module conformal_map_triangle_rows #(
  parameter int INDEX_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  cmtr_in_if.sink     in_ch,
  cmtr_out_if.source  out_ch
);
  import cmtr_pkg::*;

  localparam logic [VERT_W-1:0] IDX_MASK = (INDEX_BITS >= VERT_W) ? {VERT_W{1'b1}} :
                                           VERT_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic en;
  logic o_free;

  logic signed [COORD_W-1:0] p0 [3];
  logic signed [COORD_W-1:0] p1 [3];
  logic signed [COORD_W-1:0] p2 [3];

  // stage 1: edges
  logic                     s1_valid_r;
  tri_tag_t                 s1_tag_r;
  logic signed [DIFF_W-1:0] e1_r [3];
  logic signed [DIFF_W-1:0] e2_r [3];
  // stage 2: products
  logic                     s2_valid_r;
  tri_tag_t                 s2_tag_r;
  logic signed [PROD_W-1:0] lp_r [3];
  logic signed [PROD_W-1:0] dp_r [3];
  logic signed [PROD_W-1:0] cp_r [3];
  logic signed [PROD_W-1:0] cn_r [3];
  // stage 3: sums
  logic                     s3_valid_r;
  tri_tag_t                 s3_tag_r;
  logic signed [SUM_W-1:0]  len_r;
  logic signed [SUM_W-1:0]  dot_r;
  logic signed [SUM_W-1:0]  crs_r [3];
  // stage 4: magnitudes, index 0 is the dot product
  logic                     s4_valid_r;
  tri_tag_t                 s4_tag_r;
  tri_tag_t                 s4_tag_nxt;
  logic [PROD_W-1:0]        l1_r;
  logic [MAG_W-1:0]         mag_r [4];
  logic [SUM_W-1:0]         mag_nxt [4];
  // stage 5: square partials
  logic                     s5_valid_r;
  tri_tag_t                 s5_tag_r;
  logic [PROD_W-1:0]        l1_5_r;
  logic [2*LO_W-1:0]        pll_r [4];
  logic [LO_W+HI_W-1:0]     plh_r [4];
  logic [2*HI_W-1:0]        phh_r [4];
  // stage 6: squares
  logic                     s6_valid_r;
  tri_tag_t                 s6_tag_r;
  logic [PROD_W-1:0]        l1_6_r;
  logic [SQ_W-1:0]          sq_r [4];
  // root chain
  logic                     rv [ROOT_W+1];
  root_word_t               rw [ROOT_W+1];
  root_word_t               rw0_nxt;
  // coefficient stage
  logic                     f_valid_r;
  out_word_t                f_real_r;
  out_word_t                f_imag_r;
  out_word_t                f_real_nxt;
  out_word_t                f_imag_nxt;
  logic signed [COEF_W-1:0] ka;
  logic signed [COEF_W-1:0] kc;
  logic signed [COEF_W-1:0] kd;
  tri_tag_t                 ft;
  // output register
  logic                     o_valid_r;
  logic                     o_row_r;
  out_word_t                o_real_r;
  out_word_t                o_imag_r;

  assign o_free      = !o_valid_r || (out_ch.ready && o_row_r);
  assign en          = o_free;
  assign in_ch.ready = en;

  assign p0[0] = in_ch.data.first_x;
  assign p0[1] = in_ch.data.first_y;
  assign p0[2] = in_ch.data.first_z;
  assign p1[0] = in_ch.data.second_x;
  assign p1[1] = in_ch.data.second_y;
  assign p1[2] = in_ch.data.second_z;
  assign p2[0] = in_ch.data.third_x;
  assign p2[1] = in_ch.data.third_y;
  assign p2[2] = in_ch.data.third_z;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mag_nxt[j] = '0;
    end
    mag_nxt[0] = dot_r[SUM_W-1] ? SUM_W'(-dot_r) : SUM_W'(dot_r);
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k+1] = crs_r[k][SUM_W-1] ? SUM_W'(-crs_r[k]) : SUM_W'(crs_r[k]);
    end
    s4_tag_nxt            = s3_tag_r;
    s4_tag_nxt.dot_neg    = dot_r[SUM_W-1];
    s4_tag_nxt.degenerate = (len_r == '0) ||
                            ((crs_r[0] == '0) && (crs_r[1] == '0) && (crs_r[2] == '0));
  end

  always_comb begin
    rw0_nxt = '0;
    rw0_nxt.tag = s6_tag_r;
    rw0_nxt.lane[LANE_EDGE].rem  = RES_W'(l1_6_r);
    rw0_nxt.lane[LANE_EDGE].div  = PROD_W'(1);
    rw0_nxt.lane[LANE_DOT].rem   = RES_W'(sq_r[0]);
    rw0_nxt.lane[LANE_DOT].div   = l1_6_r;
    rw0_nxt.lane[LANE_CROSS].rem = RES_W'(sq_r[1]) + RES_W'(sq_r[2]) + RES_W'(sq_r[3]);
    rw0_nxt.lane[LANE_CROSS].div = l1_6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      rv[0]      <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      rv[0]      <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r.vert0      <= in_ch.data.first_vertex & IDX_MASK;
      s1_tag_r.vert1      <= in_ch.data.second_vertex & IDX_MASK;
      s1_tag_r.vert2      <= in_ch.data.third_vertex & IDX_MASK;
      s1_tag_r.degenerate <= 1'b0;
      s1_tag_r.dot_neg    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= DIFF_W'(p1[k]) - DIFF_W'(p0[k]);
        e2_r[k] <= DIFF_W'(p2[k]) - DIFF_W'(p0[k]);
      end

      s2_tag_r <= s1_tag_r;
      for (int k = 0; k < 3; k++) begin
        lp_r[k] <= PROD_W'(e1_r[k] * e1_r[k]);
        dp_r[k] <= PROD_W'(e1_r[k] * e2_r[k]);
        cp_r[k] <= PROD_W'(e1_r[(k + 1) % 3] * e2_r[(k + 2) % 3]);
        cn_r[k] <= PROD_W'(e1_r[(k + 2) % 3] * e2_r[(k + 1) % 3]);
      end

      s3_tag_r <= s2_tag_r;
      len_r    <= SUM_W'(lp_r[0]) + SUM_W'(lp_r[1]) + SUM_W'(lp_r[2]);
      dot_r    <= SUM_W'(dp_r[0]) + SUM_W'(dp_r[1]) + SUM_W'(dp_r[2]);
      for (int k = 0; k < 3; k++) begin
        crs_r[k] <= SUM_W'(cp_r[k]) - SUM_W'(cn_r[k]);
      end

      s4_tag_r <= s4_tag_nxt;
      l1_r <= len_r[PROD_W-1:0];
      for (int j = 0; j < 4; j++) begin
        mag_r[j] <= mag_nxt[j][MAG_W-1:0];
      end

      s5_tag_r <= s4_tag_r;
      l1_5_r   <= l1_r;
      for (int j = 0; j < 4; j++) begin
        pll_r[j] <= (2*LO_W)'(mag_r[j][LO_W-1:0] * mag_r[j][LO_W-1:0]);
        plh_r[j] <= (LO_W+HI_W)'(mag_r[j][LO_W-1:0] * mag_r[j][MAG_W-1:LO_W]);
        phh_r[j] <= (2*HI_W)'(mag_r[j][MAG_W-1:LO_W] * mag_r[j][MAG_W-1:LO_W]);
      end

      s6_tag_r <= s5_tag_r;
      l1_6_r   <= l1_5_r;
      for (int j = 0; j < 4; j++) begin
        sq_r[j] <= (SQ_W'(phh_r[j]) << (2 * LO_W)) + (SQ_W'(plh_r[j]) << (LO_W + 1))
                 + SQ_W'(pll_r[j]);
      end

      rw[0] <= rw0_nxt;
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_root
    cmtr_root_stage #(.BIT(ROOT_W - 1 - g)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (rv[g]),
      .word_in   (rw[g]),
      .valid_out (rv[g+1]),
      .word_out  (rw[g+1])
    );
  end

  always_comb begin
    ft = rw[ROOT_W].tag;
    ka = ft.degenerate ? '0 : COEF_W'(rw[ROOT_W].lane[LANE_EDGE].root);
    kd = ft.degenerate ? '0 : COEF_W'(rw[ROOT_W].lane[LANE_CROSS].root);
    kc = ft.degenerate ? '0 :
         (ft.dot_neg ? -COEF_W'(rw[ROOT_W].lane[LANE_DOT].root) :
                       COEF_W'(rw[ROOT_W].lane[LANE_DOT].root));

    f_real_nxt.imag_last     = 1'b0;
    f_real_nxt.degenerate    = ft.degenerate;
    f_real_nxt.col_first_u   = {ft.vert0, 1'b0};
    f_real_nxt.col_first_v   = {ft.vert0, 1'b1};
    f_real_nxt.col_second_u  = {ft.vert1, 1'b0};
    f_real_nxt.col_second_v  = {ft.vert1, 1'b1};
    f_real_nxt.col_third     = {ft.vert2, 1'b0};
    f_real_nxt.coef_first_u  = kc - ka;
    f_real_nxt.coef_first_v  = -kd;
    f_real_nxt.coef_second_u = -kc;
    f_real_nxt.coef_second_v = kd;
    f_real_nxt.coef_third    = ka;

    f_imag_nxt               = f_real_nxt;
    f_imag_nxt.imag_last     = 1'b1;
    f_imag_nxt.col_third     = {ft.vert2, 1'b1};
    f_imag_nxt.coef_first_u  = kd;
    f_imag_nxt.coef_first_v  = kc - ka;
    f_imag_nxt.coef_second_u = -kd;
    f_imag_nxt.coef_second_v = -kc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      o_row_r   <= 1'b0;
    end else if (o_free) begin
      f_valid_r <= rv[ROOT_W];
      o_valid_r <= f_valid_r;
      o_row_r   <= 1'b0;
    end else if (out_ch.ready) begin
      o_row_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_real_r <= f_real_nxt;
      f_imag_r <= f_imag_nxt;
      o_real_r <= f_real_r;
      o_imag_r <= f_imag_r;
    end
  end

  assign out_ch.valid = o_valid_r;
  assign out_ch.data  = o_row_r ? o_imag_r : o_real_r;
endmodule

>>> bench/conformal_map_triangle_rows_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conformal_map_triangle_rows_tb
// Drives triangle words into the row generator and checks both equation rows
// of every triangle against an exact wide-integer model of the plane
// projection. Covers directed corner cases (zero edge, collinear points,
// coordinate extremes, negative dot product) and random triangles. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module conformal_map_triangle_rows_tb;
  import cmtr_pkg::*;

  localparam int N_RANDOM    = 1880;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    in_word_t tri_word;
    bit       hold;
  } pending_tri_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cmtr_in_if  in_ch ();
  cmtr_out_if out_ch ();

  conformal_map_triangle_rows i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_tri_t pending_tris[$];
  out_word_t    row_q[$];
  int           n_errors = 0;
  int           n_tris = 0;
  int           n_rows = 0;
  int           n_degen = 0;
  int           n_cycles = 0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           stall_mode = 0;
  int           stall_left = 0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [63:0] root_floor(input logic [191:0] x);
    logic [63:0]  res;
    logic [63:0]  trial;
    logic [191:0] sq;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = res | (64'd1 << i);
      sq    = {128'd0, trial} * {128'd0, trial};
      if (sq <= x) res = trial;
    end
    return res;
  endfunction

  task automatic predict_rows(input in_word_t t);
    logic signed [191:0] p[3][3];
    logic signed [191:0] e1[3];
    logic signed [191:0] e2[3];
    logic signed [191:0] cr;
    logic signed [191:0] len1;
    logic signed [191:0] dot;
    logic [191:0]        c2;
    logic [191:0]        dm;
    logic signed [63:0]  a, c, d;
    logic [63:0]         k[2][4];
    logic                degen;
    out_word_t           row;
    p[0][0] = $signed(t.first_x);  p[0][1] = $signed(t.first_y);  p[0][2] = $signed(t.first_z);
    p[1][0] = $signed(t.second_x); p[1][1] = $signed(t.second_y); p[1][2] = $signed(t.second_z);
    p[2][0] = $signed(t.third_x);  p[2][1] = $signed(t.third_y);  p[2][2] = $signed(t.third_z);
    for (int j = 0; j < 3; j++) begin
      e1[j] = p[1][j] - p[0][j];
      e2[j] = p[2][j] - p[0][j];
    end
    len1 = 0;
    dot  = 0;
    c2   = 0;
    for (int j = 0; j < 3; j++) begin
      len1 = len1 + e1[j] * e1[j];
      dot  = dot + e1[j] * e2[j];
      cr   = e1[(j + 1) % 3] * e2[(j + 2) % 3] - e1[(j + 2) % 3] * e2[(j + 1) % 3];
      c2   = c2 + cr * cr;
    end
    degen = (len1 == 0) || (c2 == 0);
    a = 0;
    c = 0;
    d = 0;
    if (!degen) begin
      dm = (dot < 0) ? -dot : dot;
      a  = root_floor(len1);
      c  = root_floor((dm * dm) / len1);
      if (dot < 0) c = -c;
      d  = root_floor(c2 / len1);
    end
    k[0][0] = c - a; k[0][1] = -d;    k[0][2] = -c; k[0][3] = d;
    k[1][0] = d;     k[1][1] = c - a; k[1][2] = -d; k[1][3] = -c;
    for (int i = 0; i < 2; i++) begin
      row.imag_last     = (i == 1);
      row.degenerate    = degen;
      row.col_first_u   = {t.first_vertex, 1'b0};
      row.col_first_v   = {t.first_vertex, 1'b1};
      row.col_second_u  = {t.second_vertex, 1'b0};
      row.col_second_v  = {t.second_vertex, 1'b1};
      row.col_third     = {t.third_vertex, i[0]};
      row.coef_first_u  = k[i][0][COEF_W-1:0];
      row.coef_first_v  = k[i][1][COEF_W-1:0];
      row.coef_second_u = k[i][2][COEF_W-1:0];
      row.coef_second_v = k[i][3][COEF_W-1:0];
      row.coef_third    = a[COEF_W-1:0];
      row_q.push_back(row);
    end
    if (degen) n_degen++;
  endtask

  function automatic in_word_t make_tri(input logic [31:0] c[9]);
    in_word_t t;
    t.first_vertex  = VERT_W'($urandom);
    t.second_vertex = VERT_W'($urandom);
    t.third_vertex  = VERT_W'($urandom);
    t.first_x  = c[0]; t.first_y  = c[1]; t.first_z  = c[2];
    t.second_x = c[3]; t.second_y = c[4]; t.second_z = c[5];
    t.third_x  = c[6]; t.third_y  = c[7]; t.third_z  = c[8];
    return t;
  endfunction

  task automatic queue_tri(input in_word_t t, input bit hold);
    pending_tri_t p;
    p.tri_word = t;
    p.hold     = hold;
    pending_tris.push_back(p);
  endtask

  task automatic fill_directed();
    logic [31:0] c[9];
    in_word_t    t;
    localparam logic [31:0] MX = 32'h7fff_ffff;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;
    // zero edge, all corners at origin
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    t = make_tri(c); t.first_vertex = '0; t.second_vertex = '0; t.third_vertex = '0;
    queue_tri(t, 0);
    // zero edge, third corner apart
    c = '{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0};
    t = make_tri(c); t.first_vertex = '1; t.second_vertex = '1; t.third_vertex = '1;
    queue_tri(t, 0);
    // collinear
    c = '{0, 0, 0, ONE, ONE, ONE, 3 * ONE, 3 * ONE, 3 * ONE};
    queue_tri(make_tri(c), 0);
    c = '{MN, MN, MN, 0, 0, 0, MX, MX, MX};
    queue_tri(make_tri(c), 0);
    // unit right triangle and negative dot product
    c = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0};
    queue_tri(make_tri(c), 0);
    c = '{0, 0, 0, ONE, 0, 0, -2 * ONE, ONE, ONE};
    queue_tri(make_tri(c), 0);
    // coordinate extremes and tiny triangles
    c = '{MN, MN, MN, MX, MX, MX, MN, MX, MN};
    queue_tri(make_tri(c), 0);
    c = '{MX, MN, MX, MN, MX, MN, MX, MX, MN};
    queue_tri(make_tri(c), 0);
    c = '{MN, MN, MN, MX, MN, MN, MN, MX, MN};
    queue_tri(make_tri(c), 0);
    c = '{MX, MX, MX, MN, MN, MN, MX, MN, MX};
    queue_tri(make_tri(c), 0);
    c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};
    queue_tri(make_tri(c), 0);
    c = '{MN, 0, MX, MX, 0, MN, 0, MX, 0};
    queue_tri(make_tri(c), 0);
    c = '{-1, -1, -1, 1, 1, 1, 1, -1, 1};
    queue_tri(make_tri(c), 0);
    c = '{MX, MX, MX, MX, MX, MN, MN, MX, MX};
    queue_tri(make_tri(c), 0);
  endtask

  task automatic fill_random();
    logic [31:0] c[9];
    logic [31:0] base[3];
    logic [31:0] e[3];
    int          kind;
    int          m;
    int          sh;
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 99);
      for (int j = 0; j < 3; j++) base[j] = $urandom;
      if (kind < 25) begin
        for (int j = 0; j < 9; j++) c[j] = $urandom;
      end else if (kind < 80) begin
        sh = $urandom_range(0, 26);
        for (int j = 0; j < 3; j++) begin
          c[j]     = base[j];
          c[3 + j] = base[j] + ($signed($urandom) >>> sh);
          c[6 + j] = base[j] + ($signed($urandom) >>> sh);
        end
      end else if (kind < 90) begin
        // collinear: third corner on the first edge line
        m = $urandom_range(0, 6) - 3;
        for (int j = 0; j < 3; j++) begin
          e[j]     = $signed($urandom) >>> 4;
          c[j]     = base[j];
          c[3 + j] = base[j] + e[j];
          c[6 + j] = base[j] + m * e[j];
        end
      end else begin
        // zero edge
        for (int j = 0; j < 3; j++) begin
          c[j]     = base[j];
          c[3 + j] = base[j];
          c[6 + j] = $urandom;
        end
      end
      queue_tri(make_tri(c), (n == 600) || (n == 1400));
    end
  endtask

  always @(posedge clk) begin : drive_tris
    pending_tri_t p;
    bit           free;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      gap_left    <= 0;
      burst_left  <= 0;
    end else begin
      free = !(in_ch.valid && !in_ch.ready);
      if (in_ch.valid && in_ch.ready) begin
        predict_rows(in_ch.data);
        n_tris++;
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_tris.size() > 0 && !(pending_tris[0].hold && row_q.size() != 0)) begin
          p = pending_tris.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data  <= p.tri_word;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(4, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        2: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ch.ready <= (stall_left < 2);
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_rows
    out_word_t want;
    out_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      n_rows++;
      if (row_q.size() == 0) begin
        $display("%0t: row with none expected, actual %h", $time, got);
        n_errors++;
      end else begin
        want = row_q.pop_front();
        if (got.imag_last !== want.imag_last)
          $display("%0t: imag_last expected %0d actual %0d", $time, want.imag_last, got.imag_last);
        if (got.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %0d actual %0d", $time, want.degenerate, got.degenerate);
        if (got.col_first_u !== want.col_first_u)
          $display("%0t: col_first_u expected %h actual %h", $time, want.col_first_u, got.col_first_u);
        if (got.col_first_v !== want.col_first_v)
          $display("%0t: col_first_v expected %h actual %h", $time, want.col_first_v, got.col_first_v);
        if (got.col_second_u !== want.col_second_u)
          $display("%0t: col_second_u expected %h actual %h", $time, want.col_second_u,
                   got.col_second_u);
        if (got.col_second_v !== want.col_second_v)
          $display("%0t: col_second_v expected %h actual %h", $time, want.col_second_v,
                   got.col_second_v);
        if (got.col_third !== want.col_third)
          $display("%0t: col_third expected %h actual %h", $time, want.col_third, got.col_third);
        if (got.coef_first_u !== want.coef_first_u)
          $display("%0t: coef_first_u expected %h actual %h", $time, want.coef_first_u,
                   got.coef_first_u);
        if (got.coef_first_v !== want.coef_first_v)
          $display("%0t: coef_first_v expected %h actual %h", $time, want.coef_first_v,
                   got.coef_first_v);
        if (got.coef_second_u !== want.coef_second_u)
          $display("%0t: coef_second_u expected %h actual %h", $time, want.coef_second_u,
                   got.coef_second_u);
        if (got.coef_second_v !== want.coef_second_v)
          $display("%0t: coef_second_v expected %h actual %h", $time, want.coef_second_v,
                   got.coef_second_v);
        if (got.coef_third !== want.coef_third)
          $display("%0t: coef_third expected %h actual %h", $time, want.coef_third,
                   got.coef_third);
        if (got !== want) n_errors++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows outstanding", n_cycles, row_q.size());
      $display("FAIL conformal_map_triangle_rows");
      $finish;
    end
  end

  initial begin
    fill_directed();
    fill_random();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_tris.size() != 0 || in_ch.valid || row_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d triangles in, %0d rows checked, %0d degenerate triangles, %0d cycles",
             n_tris, n_rows, n_degen, n_cycles);
    $display("covered extremes, zero edges, collinear corners, burst gaps and output stalls");
    if (n_errors == 0 && row_q.size() == 0) begin
      $display("PASS conformal_map_triangle_rows");
    end else begin
      $display("FAIL conformal_map_triangle_rows");
    end
    $finish;
  end

endmodule
